>>> src/acpc_pkg.sv
// Shared types and constants for the arrow cursor pixel classifier.
`timescale 1ns / 1ps
`default_nettype none
package acpc_pkg;

  // Register indexes on the configuration port
  localparam logic REG_HEIGHT = 1'b0;
  localparam logic REG_WIDTH  = 1'b1;

  localparam logic [11:0] HEIGHT_RESET = 12'd768;
  localparam logic [11:0] WIDTH_RESET  = 12'd1024;

  // Pixel kinds
  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_OUTLINE = 2'd1;
  localparam logic [1:0] KIND_FILL    = 2'd2;

  // Glyph size floors
  localparam int HALF_MIN   = 4;
  localparam int HEAD_MIN   = 6;
  localparam int STEM_MIN   = 2;
  localparam int RADIUS_MIN = 1;

  // Glyph geometry derived from the screen height.
  // side_a = head - wing, side_b = head + wing.
  typedef struct packed {
    logic [6:0] head;
    logic [5:0] wing;
    logic [6:0] side_a;
    logic [6:0] side_b;
    logic [6:0] radius_sq;
  } glyph_t;

endpackage
`default_nettype wire

>>> src/acpc_if.sv
// Valid/ready channel interfaces for pixel requests and classification results.
`timescale 1ns / 1ps
`default_nettype none
interface acpc_pix_if;
  logic              valid;
  logic              ready;
  logic [11:0]       hot_x;
  logic [11:0]       hot_y;
  logic signed [7:0] off_x;
  logic signed [7:0] off_y;

  modport source (output valid, hot_x, hot_y, off_x, off_y, input ready);
  modport sink (input valid, hot_x, hot_y, off_x, off_y, output ready);
endinterface

interface acpc_kind_if;
  logic       valid;
  logic       ready;
  logic [1:0] pixel_kind;
  logic       on_screen;

  modport source (output valid, pixel_kind, on_screen, input ready);
  modport sink (input valid, pixel_kind, on_screen, output ready);
endinterface
`default_nettype wire

>>> src/acpc_glyph.sv
// Configuration registers and glyph sizing from the screen height.
`timescale 1ns / 1ps
`default_nettype none
module acpc_glyph #(
  parameter int REF_HEIGHT  = 768,
  parameter int HALF_BASE   = 8,
  parameter int HALF_LIMIT  = 32,
  parameter int THICK_LIMIT = 3
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [11:0]    cfg_wdata,
  output logic [11:0]         screen_height,
  output logic [11:0]         screen_width,
  output acpc_pkg::glyph_t    glyph
);
  import acpc_pkg::*;

  localparam int THICK_STEPS = HALF_LIMIT / HALF_BASE;

  function automatic glyph_t size_glyph(input logic [11:0] height);
    logic [12:0] h;
    logic [19:0] num;
    logic [6:0]  half;
    logic [4:0]  thick;
    logic [3:0]  radius;
    logic [5:0]  stem;
    glyph_t      g;
    h = (height == 12'd0) ? 13'(REF_HEIGHT) : {1'b0, height};
    num = 20'(HALF_BASE) * 20'(h) + 20'(REF_HEIGHT / 2);
    // rounded quotient, clamped, found by threshold compares
    half = 7'(HALF_MIN);
    for (int k = HALF_MIN + 1; k <= HALF_LIMIT; k++) begin
      if (num >= 20'(k * REF_HEIGHT)) half = 7'(k);
    end
    thick = 5'd0;
    for (int k = 1; k <= THICK_STEPS; k++) begin
      if (half >= 7'(k * HALF_BASE)) thick = 5'(k);
    end
    if (thick != 5'd0) thick = thick - 5'd1;
    if (thick > 5'(THICK_LIMIT)) thick = 5'(THICK_LIMIT);
    radius = (thick != 5'd0) ? thick[3:0] : 4'(RADIUS_MIN);
    stem = (half[6:1] < 6'(STEM_MIN)) ? 6'(STEM_MIN) : half[6:1];
    g.head = (half < 7'(HEAD_MIN)) ? 7'(HEAD_MIN) : half;
    g.wing = stem;
    g.side_a = g.head - {1'b0, stem};
    g.side_b = g.head + {1'b0, stem};
    g.radius_sq = 7'(radius * radius);
    return g;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height <= HEIGHT_RESET;
      screen_width  <= WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEIGHT: screen_height <= cfg_wdata;
        REG_WIDTH:  screen_width  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // registered from the stored screen height
  always_ff @(posedge clk) begin
    glyph <= size_glyph(screen_height);
  end

endmodule
`default_nettype wire

>>> src/acpc_point.sv
// Two-stage solid test of one pixel against the arrow head triangle and stem.
`timescale 1ns / 1ps
`default_nettype none
module acpc_point (
  input  wire logic              clk,
  input  wire logic              en,
  input  acpc_pkg::glyph_t       glyph,
  input  wire logic signed [8:0] px,
  input  wire logic signed [8:0] py,
  output logic                   solid
);
  import acpc_pkg::*;

  logic signed [7:0]  side_a;
  logic signed [7:0]  side_b;
  logic signed [10:0] s;
  logic signed [10:0] two_wing;
  logic [6:0]         s_clamp;
  logic [7:0]         q;
  logic signed [9:0]  ex_next;
  logic signed [9:0]  ey_next;

  // stage A products and stem offsets
  logic signed [17:0] apy, bpx, apx, bpy;
  logic               s_neg, s_pos;
  logic signed [9:0]  ex, ey;

  logic signed [17:0] o1, o3;
  logic signed [20:0] d2;
  logic               neg, pos;

  always_comb begin
    side_a = $signed({1'b0, glyph.side_a});
    side_b = $signed({1'b0, glyph.side_b});
    // projection onto base-end reduces to clamp(s, 0, 2*wing) / 2
    s = 11'(px) + 11'(py) - $signed({3'b000, glyph.head, 1'b0});
    two_wing = $signed({4'b0000, glyph.wing, 1'b0});
    if (s < 0) s_clamp = 7'd0;
    else if (s > two_wing) s_clamp = two_wing[6:0];
    else s_clamp = s[6:0];
    q = {1'b0, glyph.head} + {2'b00, s_clamp[6:1]};
    ex_next = 10'(px) - $signed({2'b00, q});
    ey_next = 10'(py) - $signed({2'b00, q});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      apy   <= side_a * py;
      bpx   <= side_b * px;
      apx   <= side_a * px;
      bpy   <= side_b * py;
      s_neg <= (s < 0);
      s_pos <= (s > 0);
      ex    <= ex_next;
      ey    <= ey_next;
    end
  end

  always_comb begin
    o1 = apy - bpx;
    o3 = apx - bpy;
    neg = (o1 < 0) || (o3 < 0) || s_neg;
    pos = (o1 > 0) || (o3 > 0) || s_pos;
    d2 = ex * ex + ey * ey;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      solid <= !(neg && pos) || (d2 <= $signed({14'd0, glyph.radius_sq}));
    end
  end

endmodule
`default_nettype wire

>>> src/arrow_cursor_pixel_classifier.sv
// Top level of the arrow cursor pixel classifier.
// Usage:
//   The pixel channel carries a cursor hotspot (hot_x, hot_y) and a signed
//   pixel offset (off_x, off_y). For each item the result channel returns
//   pixel_kind (transparent, black outline or white fill) and on_screen.
//   The glyph is sized from screen_height (register 0); screen_width
//   (register 1) only clips. Write registers while no item is in flight.
// Throughput: one item per cycle while results are taken. The pipeline
//   has four register stages: input capture with clipping, products of
//   five point tests, the solid decisions, and the output register with
//   the outline/fill choice.
// Stall: when the result register holds an item that is not taken, the
//   whole pipeline holds and pixel.ready falls; nothing is lost or repeated.
// Reset: rst empties the pipeline and sets the height to 768 and the width
//   to 1024. The glyph register follows the height register.
`timescale 1ns / 1ps
`default_nettype none
module arrow_cursor_pixel_classifier #(
  parameter int REF_HEIGHT  = 768,
  parameter int HALF_BASE   = 8,
  parameter int HALF_LIMIT  = 32,
  parameter int THICK_LIMIT = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [11:0] cfg_wdata,
  acpc_pix_if.sink         pixel,
  acpc_kind_if.source      result
);
  import acpc_pkg::*;

  localparam int NPTS = 5;

  logic [11:0] screen_height;
  logic [11:0] screen_width;
  glyph_t      glyph;

  logic              advance;
  logic signed [13:0] sx, sy;
  logic               vis_next;

  logic              v1, v2, v3;
  logic              vis1, vis2, vis3;
  logic signed [7:0] ox1, oy1;

  logic signed [8:0] px_pt [NPTS];
  logic signed [8:0] py_pt [NPTS];
  logic [NPTS-1:0]   solid;

  logic       out_valid;
  logic [1:0] kind;
  logic       out_vis;
  logic [1:0] kind_next;

  acpc_glyph #(
    .REF_HEIGHT (REF_HEIGHT),
    .HALF_BASE  (HALF_BASE),
    .HALF_LIMIT (HALF_LIMIT),
    .THICK_LIMIT(THICK_LIMIT)
  ) u_glyph (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .screen_height(screen_height),
    .screen_width (screen_width),
    .glyph        (glyph)
  );

  assign advance = !out_valid || result.ready;
  assign pixel.ready = advance;

  always_comb begin
    sx = $signed({2'b00, pixel.hot_x}) + 14'(pixel.off_x);
    sy = $signed({2'b00, pixel.hot_y}) + 14'(pixel.off_y);
    vis_next = (sx >= 0) && (sy >= 0)
            && (sx < $signed({2'b00, screen_width}))
            && (sy < $signed({2'b00, screen_height}));
  end

  // center, left, right, up, down
  always_comb begin
    px_pt[0] = 9'(ox1);
    py_pt[0] = 9'(oy1);
    px_pt[1] = 9'(ox1) - 9'sd1;
    py_pt[1] = 9'(oy1);
    px_pt[2] = 9'(ox1) + 9'sd1;
    py_pt[2] = 9'(oy1);
    px_pt[3] = 9'(ox1);
    py_pt[3] = 9'(oy1) - 9'sd1;
    px_pt[4] = 9'(ox1);
    py_pt[4] = 9'(oy1) + 9'sd1;
  end

  for (genvar i = 0; i < NPTS; i++) begin : g_pt
    acpc_point u_point (
      .clk  (clk),
      .en   (advance),
      .glyph(glyph),
      .px   (px_pt[i]),
      .py   (py_pt[i]),
      .solid(solid[i])
    );
  end

  always_comb begin
    if (solid[0]) kind_next = KIND_FILL;
    else if (|solid[NPTS-1:1]) kind_next = KIND_OUTLINE;
    else kind_next = KIND_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= pixel.valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ox1     <= pixel.off_x;
      oy1     <= pixel.off_y;
      vis1    <= vis_next;
      vis2    <= vis1;
      vis3    <= vis2;
      kind    <= kind_next;
      out_vis <= vis3;
    end
  end

  assign result.valid      = out_valid;
  assign result.pixel_kind = kind;
  assign result.on_screen  = out_vis;

endmodule
`default_nettype wire
